/* design/masked_byte_pattern_search_defines.svh */
// Assertion macros used by the masked byte pattern search RTL
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition holds on the edge after a trigger
`define MBPS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define MBPS_ASSERT(lbl, prop, msg)
`define MBPS_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

/* design/mbps_pkg.sv */
// Shared types and constants of the masked byte pattern search
`default_nettype none
package mbps_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int SEEN_W  = 48;
  localparam int ADDR_W  = 64;
  localparam int DATA_W  = 64;
  localparam int PAT_W   = 128;
  localparam int MASK_W  = 16;
  localparam int PADDR_W = 6;
  localparam int REG_W   = 3;

  // Register indexes, taken from paddr[5:3]
  localparam logic [REG_W-1:0] REG_PAT_LO = 3'd0;
  localparam logic [REG_W-1:0] REG_PAT_HI = 3'd1;
  localparam logic [REG_W-1:0] REG_CARE   = 3'd2;
  localparam logic [REG_W-1:0] REG_LEN    = 3'd3;
  localparam logic [REG_W-1:0] REG_BASE   = 3'd4;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  // Control broadcast to every cell of the window
  typedef struct packed {
    logic             shift;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/mbps_cell.sv */
// One window cell: holds a byte and compares its incoming byte against the pattern
`default_nettype none
module mbps_cell #(
  parameter int IDX = 0
) (
  input  wire                            clk,
  input  wire  mbps_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [mbps_pkg::PAT_W-1:0]     pattern_i,
  input  wire  [mbps_pkg::MASK_W-1:0]    care_i,
  input  wire  [mbps_pkg::BYTE_W-1:0]    byte_i,
  output logic [mbps_pkg::BYTE_W-1:0]    byte_o,
  output logic                           hit_o
);

  logic [mbps_pkg::BYTE_W-1:0] byte_r;
  logic [mbps_pkg::BYTE_W-1:0] byte_nxt;
  logic [mbps_pkg::LEN_W-1:0]  sel;
  logic                        active;
  logic [mbps_pkg::BYTE_W-1:0] pat_byte;
  logic                        care;

  // This cell compares window entry IDX, its incoming byte, against pattern byte len-1-IDX
  assign sel      = ctrl_i.len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(IDX);
  assign active   = mbps_pkg::LEN_W'(IDX) < ctrl_i.len;
  assign pat_byte = pattern_i[sel[3:0]*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
  assign care     = care_i[sel[3:0]];
  assign hit_o    = !active || !care || (byte_i == pat_byte);

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl_i.shift) begin
      byte_nxt = byte_i;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_o = byte_r;

endmodule
`default_nettype wire

/* design/masked_byte_pattern_search.sv */
// Top level of the masked byte pattern search: config registers, cell row, result buffer
//
//  Channel   Direction  Handshake                     Payload
//  in_       input      in_valid / in_ready           in_data_byte, in_last_byte
//  out_      output     out_valid / out_ready         out_found, out_match_address
//  APB       config     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One byte is taken per cycle unless the skid word waits; the window compare and the
// address sum sit in the accept cycle and the result is registered.
// The result buffer holds two words: input stalls only when both are waiting.
// Reset (synchronous, rst_n low) empties the buffer and the region state, holds
// in_ready low and restores the registers: pattern_length 1, all others zero.
`default_nettype none
`include "masked_byte_pattern_search_defines.svh"
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // byte stream
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [mbps_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire                              in_last_byte,
  // results
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_found,
  output logic [mbps_pkg::ADDR_W-1:0]      out_match_address,
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mbps_pkg::PADDR_W-1:0]     paddr,
  input  wire  [mbps_pkg::DATA_W-1:0]      pwdata,
  output logic [mbps_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam logic [mbps_pkg::SEEN_W-1:0] SEEN_MAX = {mbps_pkg::SEEN_W{1'b1}};

  // ---------------- configuration registers ----------------
  logic [mbps_pkg::DATA_W-1:0] pat_lo_r;
  logic [mbps_pkg::DATA_W-1:0] pat_hi_r;
  logic [mbps_pkg::MASK_W-1:0] care_r;
  logic [mbps_pkg::LEN_W-1:0]  len_r;
  logic [mbps_pkg::ADDR_W-1:0] base_r;
  logic [mbps_pkg::REG_W-1:0]  reg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= mbps_pkg::LEN_RESET;
      base_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mbps_pkg::REG_PAT_LO: pat_lo_r <= pwdata;
        mbps_pkg::REG_PAT_HI: pat_hi_r <= pwdata;
        mbps_pkg::REG_CARE:   care_r   <= pwdata[mbps_pkg::MASK_W-1:0];
        mbps_pkg::REG_LEN:    len_r    <= pwdata[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_BASE:   base_r   <= pwdata;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbps_pkg::REG_PAT_LO: prdata = pat_lo_r;
      mbps_pkg::REG_PAT_HI: prdata = pat_hi_r;
      mbps_pkg::REG_CARE:   prdata = mbps_pkg::DATA_W'(care_r);
      mbps_pkg::REG_LEN:    prdata = mbps_pkg::DATA_W'(len_r);
      mbps_pkg::REG_BASE:   prdata = base_r;
      default:              prdata = '0;
    endcase
  end

  // Clamp the pattern length to the number of cells
  logic [mbps_pkg::LEN_W-1:0] len_eff;
  assign len_eff = (len_r > mbps_pkg::LEN_W'(MAX_PATTERN)) ?
                   mbps_pkg::LEN_W'(MAX_PATTERN) : len_r;

  // ---------------- cell row ----------------
  logic                        in_fire;
  mbps_pkg::cell_ctrl_t        cell_ctrl;
  logic [mbps_pkg::BYTE_W-1:0] chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0]      cell_hit;
  logic                        win_hit;

  assign in_fire        = in_valid && in_ready;
  assign cell_ctrl.shift = in_fire;
  assign cell_ctrl.len   = len_eff;
  assign chain[0]       = in_data_byte;

  // Cell k holds the byte seen k bytes before the newest; the newest enters cell 0.
  // The last cell's held byte leaves the row at the tail and takes no part in the compare.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    mbps_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .ctrl_i   (cell_ctrl),
      .pattern_i({pat_hi_r, pat_lo_r}),
      .care_i   (care_r),
      .byte_i   (chain[k]),
      .byte_o   (chain[k+1]),
      .hit_o    (cell_hit[k])
    );
  end

  assign win_hit = &cell_hit;

  // ---------------- region state ----------------
  logic [mbps_pkg::SEEN_W-1:0] seen_r;
  logic [mbps_pkg::SEEN_W-1:0] seen_nxt;
  logic                        match_reported_r;
  logic                        match_reported_nxt;
  logic [mbps_pkg::SEEN_W-1:0] seen_inc;
  logic [mbps_pkg::SEEN_W-1:0] offset;
  logic                        hit;
  logic                        res_fire;
  logic [mbps_pkg::ADDR_W-1:0] res_addr;
  logic                        last_fire;
  logic                        region_clear;

  // Count saturates; the compare covers the byte being accepted
  assign seen_inc = (seen_r == SEEN_MAX) ? seen_r : seen_r + mbps_pkg::SEEN_W'(1);
  assign offset   = seen_inc - mbps_pkg::SEEN_W'(len_eff);
  assign hit      = !match_reported_r && (base_r != '0) && (len_eff != '0) &&
                    (seen_inc >= mbps_pkg::SEEN_W'(len_eff)) && win_hit;
  assign res_fire = in_fire && (hit || (in_last_byte && !match_reported_r));
  assign res_addr = hit ? base_r + mbps_pkg::ADDR_W'(offset) : '0;

  assign last_fire    = in_fire && in_last_byte;
  assign region_clear = (seen_r == '0) && !match_reported_r;

  always_comb begin
    seen_nxt           = seen_r;
    match_reported_nxt = match_reported_r;
    if (in_fire) begin
      if (in_last_byte) begin
        // end of region: drop the count and the reported flag
        seen_nxt           = '0;
        match_reported_nxt = 1'b0;
      end else begin
        seen_nxt           = seen_inc;
        match_reported_nxt = match_reported_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r           <= '0;
      match_reported_r <= 1'b0;
    end else begin
      seen_r           <= seen_nxt;
      match_reported_r <= match_reported_nxt;
    end
  end

  // ---------------- result buffer: output word plus skid word ----------------
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_found_r;
  logic                        out_found_nxt;
  logic [mbps_pkg::ADDR_W-1:0] out_addr_r;
  logic [mbps_pkg::ADDR_W-1:0] out_addr_nxt;
  logic                        skid_valid_r;
  logic                        skid_valid_nxt;
  logic                        skid_found_r;
  logic                        skid_found_nxt;
  logic [mbps_pkg::ADDR_W-1:0] skid_addr_r;
  logic [mbps_pkg::ADDR_W-1:0] skid_addr_nxt;
  logic                        pop;

  assign pop      = out_valid_r && out_ready;
  // hold the input off in reset and while the skid word waits
  assign in_ready = rst_n && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r && !pop;
    out_found_nxt  = out_found_r;
    out_addr_nxt   = out_addr_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    skid_addr_nxt  = skid_addr_r;
    if (skid_valid_r) begin
      // input is held; advance the skid word once the output word leaves
      if (pop) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = skid_found_r;
        out_addr_nxt   = skid_addr_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = hit;
        out_addr_nxt  = res_addr;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_found_nxt = hit;
        skid_addr_nxt  = res_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_addr_r   <= out_addr_nxt;
    skid_found_r <= skid_found_nxt;
    skid_addr_r  <= skid_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

  // ---------------- checks ----------------
  `MBPS_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid word without output word")
  `MBPS_ASSERT_NEXT(a_region_cleared, last_fire, region_clear, "region kept after final byte")
  `MBPS_ASSERT(a_reported_needs_bytes, match_reported_r |-> (seen_r != '0), "match flag, no bytes")
  `MBPS_ASSERT(a_notfound_addr, out_valid_r && !out_found_r |-> out_addr_r == '0, "not-found address")
  `MBPS_ASSERT_NEXT(a_tail_shift, in_fire, chain[MAX_PATTERN] === $past(chain[MAX_PATTERN-1]), "tail")

endmodule
`default_nettype wire
